### rtl/core/adc_code_to_volt_text_defines.svh
// Assertion macros shared by the checker of the converter code to voltage text block.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ADC_CODE_TO_VOLT_TEXT_DEFINES_SVH
`define ADC_CODE_TO_VOLT_TEXT_DEFINES_SVH

// Implication checked in the same cycle.
`define ACVT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acvt: same-cycle check failed");

// Implication checked in the following cycle.
`define ACVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acvt: next-cycle check failed");

`endif

### rtl/core/acvt_pkg.sv
// Package of the converter code to voltage text block: widths, constants, types.
// Used by the front, queue, back and top-level modules; depends on nothing.
package acvt_pkg;

  localparam int CodeW  = 24;
  localparam int ChanW  = 8;
  localparam int TypeW  = 8;
  localparam int ByteW  = 8;
  localparam int MagW   = 22;
  localparam int ProdW  = 46;
  localparam int SumW   = 23;
  localparam int ThrW   = 24;
  localparam int StepW  = 4;
  localparam int PowIdxW = 3;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [MagW-1:0]  UniSpan   = MagW'(2500000);
  localparam logic [SumW-1:0]  BiOffset  = SumW'(2500000);
  localparam logic [TypeW-1:0] UniTypeLo = TypeW'(33);
  localparam logic [TypeW-1:0] UniTypeHi = TypeW'(36);
  localparam int               RowShift  = 6;
  localparam logic [ByteW-1:0] ColOffset = ByteW'(3);
  localparam logic [ByteW-1:0] BaseReset = ByteW'(128);

  localparam logic [ByteW-1:0] CharMinus = 8'h2D;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharPoint = 8'h2E;

  localparam logic [StepW-1:0] StepAddr  = 4'd0;
  localparam logic [StepW-1:0] StepSign  = 4'd1;
  localparam logic [StepW-1:0] StepUnits = 4'd2;
  localparam logic [StepW-1:0] StepPoint = 4'd3;
  localparam logic [StepW-1:0] StepLast  = 4'd9;
  localparam logic [PowIdxW-1:0] UnitsPow = 3'd6;

  localparam int CfgAddrW = 3;
  localparam logic RegBaseIdx = 1'b0;

  typedef struct packed {
    logic             neg;
    logic [MagW-1:0]  mag;
    logic [ByteW-1:0] addr;
  } acvt_entry_t;

  function automatic logic [ThrW-1:0] pow10(input logic [PowIdxW-1:0] idx);
    logic [ThrW-1:0] val;
    case (idx)
      3'd0: val = ThrW'(1);
      3'd1: val = ThrW'(10);
      3'd2: val = ThrW'(100);
      3'd3: val = ThrW'(1000);
      3'd4: val = ThrW'(10000);
      3'd5: val = ThrW'(100000);
      3'd6: val = ThrW'(1000000);
      default: val = ThrW'(1000000);
    endcase
    return val;
  endfunction

endpackage

### rtl/core/acvt_front.sv
// Front part: accepts samples, scales them to microvolts and forms the address byte.
// Depends on acvt_pkg.
module acvt_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [acvt_pkg::CodeW-1:0] code_i,
  input  logic [acvt_pkg::ChanW-1:0] chan_i,
  input  logic [acvt_pkg::TypeW-1:0] type_i,
  input  logic [acvt_pkg::ByteW-1:0] base_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output acvt_pkg::acvt_entry_t      push_entry_o
);
  import acvt_pkg::*;

  logic            valid_q, valid_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic            uni_q, uni_d;
  logic [ByteW-1:0] addr_q, addr_d;
  logic [ProdW-1:0] prod;
  logic            accept;
  logic            neg;

  assign in_ready_o = !valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign prod       = ProdW'(code_i) * ProdW'(UniSpan);

  always_comb begin
    valid_d = valid_q;
    sum_d   = sum_q;
    uni_d   = uni_q;
    addr_d  = addr_q;
    if (accept) begin
      valid_d = 1'b1;
      sum_d   = prod[ProdW-1 -: SumW];
      uni_d   = (type_i >= UniTypeLo) && (type_i <= UniTypeHi);
      addr_d  = base_i | ByteW'(({ChanW'(0), chan_i} << RowShift) + {ChanW'(0), ColOffset});
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    neg = 1'b0;
    push_entry_o.addr = addr_q;
    if (uni_q) begin
      push_entry_o.mag = sum_q[SumW-1:1];
    end else if (sum_q < BiOffset) begin
      neg = 1'b1;
      push_entry_o.mag = MagW'(BiOffset - sum_q);
    end else begin
      push_entry_o.mag = MagW'(sum_q - BiOffset);
    end
    push_entry_o.neg = neg;
  end

  assign push_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    uni_q  <= uni_d;
    addr_q <= addr_d;
  end

endmodule

### rtl/core/acvt_queue.sv
// Short register queue between the front and back parts.
// Depends on acvt_pkg.
module acvt_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  acvt_pkg::acvt_entry_t push_entry_i,
  output logic                  head_valid_o,
  input  logic                  pop_i,
  output acvt_pkg::acvt_entry_t head_entry_o
);
  import acvt_pkg::*;

  acvt_entry_t      entries_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = count_q != QCntW'(QDepth);
  assign head_valid_o = count_q != '0;
  assign head_entry_o = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

### rtl/core/acvt_back.sv
// Back part: emits the address command and the nine text characters, one digit per step.
// Depends on acvt_pkg.
module acvt_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  acvt_pkg::acvt_entry_t      head_entry_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [acvt_pkg::ByteW-1:0] out_byte_o,
  output logic                       out_instr_o,
  output logic                       out_last_o
);
  import acvt_pkg::*;

  logic [StepW-1:0]   step_q, step_d;
  logic [MagW-1:0]    rem_q, rem_d;
  logic               valid_q, valid_d;
  logic [ByteW-1:0]   byte_q, byte_d;
  logic               instr_q, instr_d;
  logic               last_q, last_d;
  logic               emit;
  logic [PowIdxW-1:0] pidx;
  logic [ThrW-1:0]    thr [10];
  logic [StepW-1:0]   digit;

  assign emit  = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o = emit && (step_q == StepLast);

  always_comb begin
    pidx = (step_q == StepUnits) ? UnitsPow : PowIdxW'(StepLast - step_q);
    thr[0] = '0;
    digit  = '0;
    for (int m = 1; m < 10; m++) begin
      thr[m] = ThrW'(m) * pow10(pidx);
      if (ThrW'(rem_q) >= thr[m]) begin
        digit = StepW'(m);
      end
    end
  end

  always_comb begin
    step_d  = step_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    instr_d = instr_q;
    last_d  = last_q;
    if (emit) begin
      valid_d = 1'b1;
      instr_d = 1'b0;
      last_d  = step_q == StepLast;
      step_d  = (step_q == StepLast) ? StepAddr : step_q + 1'b1;
      case (step_q)
        StepAddr: begin
          byte_d  = head_entry_i.addr;
          instr_d = 1'b1;
        end
        StepSign: begin
          byte_d = head_entry_i.neg ? CharMinus : CharSpace;
          rem_d  = head_entry_i.mag;
        end
        StepPoint: begin
          byte_d = CharPoint;
        end
        default: begin
          byte_d = CharZero + ByteW'(digit);
          rem_d  = MagW'(ThrW'(rem_q) - thr[digit]);
        end
      endcase
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_instr_o = instr_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StepAddr;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    byte_q  <= byte_d;
    instr_q <= instr_d;
    last_q  <= last_d;
  end

endmodule

### rtl/core/adc_code_to_volt_text.sv
// Top level of the converter code to voltage text block: stream ports and the config register.
// Instantiates acvt_front, acvt_queue and acvt_back; depends on acvt_pkg.
// The address command passes the front register, a queue entry and the back output register.
// Throughput: ten result bytes per sample, one per cycle while m_axis_tready_i is high, set by
// the one-byte result port; two more samples are buffered meanwhile.
// Reset: rst_ni low clears all handshake state and sets the address base to 128.
module adc_code_to_volt_text (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i,  // sample_code[23:0], channel[31:24]
  input  logic [acvt_pkg::TypeW-1:0]    s_axis_tuser_i,  // msg_type[7:0]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [acvt_pkg::ByteW-1:0]    m_axis_tdata_o,  // out_byte[7:0]
  output logic                          m_axis_tuser_o,  // is_instruction[0]
  output logic                          m_axis_tlast_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acvt_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import acvt_pkg::*;

  logic [ByteW-1:0] base_q, base_d;
  logic             push_valid, push_ready, head_valid, pop;
  acvt_entry_t      push_entry, head_entry;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == RegBaseIdx;
  assign prdata  = reg_sel ? {24'd0, base_q} : 32'd0;

  always_comb begin
    base_d = base_q;
    if (psel && penable && pwrite && reg_sel) begin
      base_d = pwdata[ByteW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else begin
      base_q <= base_d;
    end
  end

  acvt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .code_i       (s_axis_tdata_i[CodeW-1:0]),
    .chan_i       (s_axis_tdata_i[CodeW+ChanW-1:CodeW]),
    .type_i       (s_axis_tuser_i),
    .base_i       (base_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  acvt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_entry_o (head_entry)
  );

  acvt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_instr_o  (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

### rtl/core/acvt_checker.sv
// Port-level checker of the converter code to voltage text block, bound to its top level.
// Depends on adc_code_to_volt_text_defines.svh.
`include "adc_code_to_volt_text_defines.svh"

module acvt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic out_hs;
  assign out_hs = m_axis_tvalid_o && m_axis_tready_i;

  // A stalled result keeps its byte.
  `ACVT_ASSERT_NEXT(stall_hold_a, m_axis_tvalid_o && !m_axis_tready_i,
                    m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // The address command never closes a run.
  `ACVT_ASSERT_NOW(instr_not_last_a, out_hs && m_axis_tuser_o, !m_axis_tlast_o)

  // The final character of a run is a decimal digit.
  `ACVT_ASSERT_NOW(last_is_digit_a, out_hs && m_axis_tlast_o,
                   !m_axis_tuser_o && m_axis_tdata_o >= 8'h30 && m_axis_tdata_o <= 8'h39)

  // The decimal point is followed by digits, so it is never the last character.
  `ACVT_ASSERT_NOW(point_not_last_a, out_hs && !m_axis_tuser_o && m_axis_tdata_o == 8'h2E,
                   !m_axis_tlast_o)

endmodule

bind adc_code_to_volt_text acvt_checker u_checker (.*);
